// ===== src/pidl_pkg.sv =====
package pidl_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_READ    = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_REPLACE = 3'd3,
    ACT_DELETE  = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

// ===== src/positional_insert_delete_list_unit.sv =====
// append, replace, clear, errors and insert at the end finish without moving entries; read waits
// on the registered ram read; insert below the end and delete (but for the last entry) shift the
// entries after the position, and insert then writes the new value into the freed slot
// one entry moves per cycle through the single-port-write ram, so shift length sets the rate
// the next input transaction is taken once the result is in the output register
// rst_n (synchronous, active low) empties the list; entry contents are not cleared
module positional_insert_delete_list_unit #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // action[2:0], value[34:3], position[41:35], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], count[39:32], status[41:40], zero pad
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > 7) ? CW : 7;
  localparam int DW    = pidl_pkg::DATA_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_FILL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       src_r, src_nxt;
  logic [AW-1:0]       wr_r, wr_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [DW-1:0]       val_r, val_nxt;
  logic [DW-1:0]       rd_r, rd_nxt;
  pidl_pkg::status_t   st_r, st_nxt;
  logic                ins_r, ins_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DW-1:0]       out_rd_r, out_rd_nxt;
  logic [7:0]          out_cnt_r, out_cnt_nxt;
  pidl_pkg::status_t   out_st_r, out_st_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [DW-1:0]       ram_rdata;

  pidl_pkg::action_t   in_action;
  logic [DW-1:0]       in_value;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [AW-1:0]       step;
  logic                is_full;
  logic                is_empty;

  assign in_action = pidl_pkg::action_t'(in_tdata[2:0]);
  assign in_value  = in_tdata[34:3];
  assign pos_ext   = CMP_W'(in_tdata[41:35]);
  assign cnt_ext   = CMP_W'(count_r);
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);

  // shared index unit: walks down for insert, up for delete
  assign step = ins_r ? AW'(src_r - 1'b1) : AW'(src_r + 1'b1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_st_r, out_cnt_r, out_rd_r};

  pidl_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    src_nxt       = src_r;
    wr_nxt        = wr_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    rd_nxt        = rd_r;
    st_nxt        = st_r;
    ins_nxt       = ins_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rd_nxt    = out_rd_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = src_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pos_nxt   = AW'(pos_ext);
          val_nxt   = in_value;
          rd_nxt    = '0;
          st_nxt    = pidl_pkg::ST_OK;
          state_nxt = S_DONE;
          unique case (in_action)
            pidl_pkg::ACT_APPEND: begin
              if (is_full) begin
                st_nxt = pidl_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_r);
                ram_wdata = in_value;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            pidl_pkg::ACT_READ: begin
              if (is_empty) begin
                st_nxt = pidl_pkg::ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                st_nxt = pidl_pkg::ST_RANGE;
              end else begin
                ram_raddr = AW'(pos_ext);
                state_nxt = S_READ;
              end
            end
            pidl_pkg::ACT_INSERT: begin
              if (is_full) begin
                st_nxt = pidl_pkg::ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                st_nxt = pidl_pkg::ST_RANGE;
              end else begin
                count_nxt = CW'(count_r + 1'b1);
                if (pos_ext == cnt_ext) begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(pos_ext);
                  ram_wdata = in_value;
                end else begin
                  ins_nxt   = 1'b1;
                  src_nxt   = AW'(count_r - 1'b1);
                  wr_nxt    = AW'(count_r);
                  ram_raddr = AW'(count_r - 1'b1);
                  state_nxt = S_SHIFT;
                end
              end
            end
            pidl_pkg::ACT_REPLACE: begin
              if (pos_ext >= cnt_ext) begin
                st_nxt = pidl_pkg::ST_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(pos_ext);
                ram_wdata = in_value;
              end
            end
            pidl_pkg::ACT_DELETE: begin
              if (is_empty) begin
                st_nxt = pidl_pkg::ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                st_nxt = pidl_pkg::ST_RANGE;
              end else begin
                count_nxt = CW'(count_r - 1'b1);
                // deleting the last live entry needs no move
                if (CMP_W'(pos_ext + 1'b1) != cnt_ext) begin
                  ins_nxt   = 1'b0;
                  src_nxt   = AW'(pos_ext + 1'b1);
                  wr_nxt    = AW'(pos_ext);
                  ram_raddr = AW'(pos_ext + 1'b1);
                  state_nxt = S_SHIFT;
                end
              end
            end
            pidl_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        // ram_rdata holds the entry at src_r, read last cycle
        ram_we    = 1'b1;
        ram_waddr = wr_r;
        ram_wdata = ram_rdata;
        if ((ins_r && (src_r == pos_r)) || (!ins_r && (CW'(src_r) == count_r))) begin
          state_nxt = ins_r ? S_FILL : S_DONE;
        end else begin
          src_nxt   = step;
          wr_nxt    = src_r;
          ram_raddr = step;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_cnt_nxt   = 8'(count_r);
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    wr_r      <= wr_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    rd_r      <= rd_nxt;
    st_r      <= st_nxt;
    ins_r     <= ins_nxt;
    out_rd_r  <= out_rd_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule

// ===== src/pidl_ram.sv =====
module pidl_ram #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pidl_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [pidl_pkg::DATA_W-1:0] rd_data
);

  logic [pidl_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int LIST_DEPTH = 128;
  localparam int CMD_TARGET = 1425;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 16;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 400;
  // action codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  act;
    logic [31:0] val;
    logic [6:0]  pos;
    logic        drain;
  } list_cmd_t;

  typedef struct packed {
    logic [31:0]       rd;
    logic [7:0]        cnt;
    pidl_pkg::status_t st;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // action[2:0], value[34:3], position[41:35], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // read_value[31:0], count[39:32], status[41:40], zero pad

  list_cmd_t    cmd_q[$];
  list_result_t list_results_q[$];

  logic [31:0] model_mem [LIST_DEPTH];
  int          model_len = 0;
  int          gen_len = 0;
  int          gen_total = 0;
  int          n_sent = 0;
  int          n_results = 0;
  int          n_errors = 0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic        in_took = 1'b0;

  positional_insert_delete_list_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // list behavior, applied once per accepted input transaction
  function automatic list_result_t apply_list_action(input logic [47:0] word);
    logic [2:0]   act;
    logic [31:0]  val;
    int           pos;
    list_result_t res;
    act = word[2:0];
    val = word[34:3];
    pos = int'(word[41:35]);
    res.rd = '0;
    res.st = pidl_pkg::ST_OK;
    case (act)
      pidl_pkg::ACT_APPEND: begin
        if (model_len >= LIST_DEPTH) res.st = pidl_pkg::ST_FULL;
        else begin
          model_mem[model_len] = val;
          model_len++;
        end
      end
      pidl_pkg::ACT_READ: begin
        if (model_len == 0) res.st = pidl_pkg::ST_EMPTY;
        else if (pos >= model_len) res.st = pidl_pkg::ST_RANGE;
        else res.rd = model_mem[pos];
      end
      pidl_pkg::ACT_INSERT: begin
        if (model_len >= LIST_DEPTH) res.st = pidl_pkg::ST_FULL;
        else if (pos > model_len) res.st = pidl_pkg::ST_RANGE;
        else begin
          for (int i = model_len; i > pos; i--) model_mem[i] = model_mem[i - 1];
          model_mem[pos] = val;
          model_len++;
        end
      end
      pidl_pkg::ACT_REPLACE: begin
        if (pos >= model_len) res.st = pidl_pkg::ST_RANGE;
        else model_mem[pos] = val;
      end
      pidl_pkg::ACT_DELETE: begin
        if (model_len == 0) res.st = pidl_pkg::ST_EMPTY;
        else if (pos >= model_len) res.st = pidl_pkg::ST_RANGE;
        else begin
          for (int i = pos; i + 1 < model_len; i++) model_mem[i] = model_mem[i + 1];
          model_len--;
        end
      end
      pidl_pkg::ACT_CLEAR: model_len = 0;
      default: ;
    endcase
    res.cnt = 8'(model_len);
    return res;
  endfunction

  // queue one command and track the list length it leaves behind
  task automatic add_cmd(input logic [2:0] act, input logic [31:0] val, input int pos);
    list_cmd_t c;
    c.act = act;
    c.val = val;
    c.pos = 7'(pos);
    c.drain = (gen_total != 0) && (gen_total % 350 == 0);
    cmd_q.push_back(c);
    gen_total++;
    case (act)
      pidl_pkg::ACT_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
      pidl_pkg::ACT_INSERT: if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
      pidl_pkg::ACT_DELETE: if (gen_len != 0 && pos < gen_len) gen_len--;
      pidl_pkg::ACT_CLEAR: gen_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly a live position, now and then anything the field holds
  function automatic int pick_pos(input int span);
    if (span > LIST_DEPTH) span = LIST_DEPTH;
    if (span <= 0 || $urandom_range(99) < 12) begin
      return ($urandom_range(9) == 0) ? 127 : $urandom_range(127);
    end
    return $urandom_range(span - 1);
  endfunction

  function automatic int idle_pct(input int n, input bit rx_side);
    case ((n / 100) % 4)
      1: return rx_side ? 0 : 47;
      2: return rx_side ? 47 : 0;
      3: return 37;
      default: return 0;
    endcase
  endfunction

  // sender: one transaction offered at a time, held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (cmd_q.size() == 0 || $urandom_range(99) < idle_pct(n_sent, 1'b0) ||
          (cmd_q[0].drain && list_results_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        list_cmd_t c;
        c = cmd_q.pop_front();
        in_tdata <= {6'b0, c.pos, c.val, c.act};
        in_tvalid <= 1'b1;
        n_sent++;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct(n_results, 1'b1));
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) list_results_q.push_back(apply_list_action(in_tdata));
      if (out_tvalid && out_tready) begin
        n_results++;
        if (list_results_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata[31:0], '0);
        end else begin
          list_result_t want;
          want = list_results_q.pop_front();
          if (out_tdata[31:0] !== want.rd)
            report_mismatch("read_value", out_tdata[31:0], want.rd);
          if (out_tdata[39:32] !== want.cnt)
            report_mismatch("count", 32'(out_tdata[39:32]), 32'(want.cnt));
          if (out_tdata[41:40] !== want.st)
            report_mismatch("status", 32'(out_tdata[41:40]), 32'(want.st));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int target;
    int ops;
    int k;
    logic [2:0] act;

    // edge cases on an empty list, then a small list
    add_cmd(pidl_pkg::ACT_READ, 32'h0, 0);
    add_cmd(pidl_pkg::ACT_DELETE, 32'h0, 0);
    add_cmd(pidl_pkg::ACT_REPLACE, 32'h1, 0);
    add_cmd(pidl_pkg::ACT_INSERT, 32'h2, 1);
    add_cmd(pidl_pkg::ACT_INSERT, 32'h7fff_ffff, 0);
    add_cmd(pidl_pkg::ACT_APPEND, 32'h8000_0000, 0);
    add_cmd(pidl_pkg::ACT_APPEND, 32'h0000_0000, 0);
    add_cmd(pidl_pkg::ACT_APPEND, 32'hffff_ffff, 0);
    add_cmd(pidl_pkg::ACT_INSERT, 32'h1234_5678, 4);     // position equal to count: at the end
    add_cmd(pidl_pkg::ACT_INSERT, 32'h5a5a_5a5a, 2);
    for (int i = 0; i < 6; i++) add_cmd(pidl_pkg::ACT_READ, 32'h0, i);
    add_cmd(pidl_pkg::ACT_READ, 32'h0, 6);
    add_cmd(pidl_pkg::ACT_READ, 32'hffff_ffff, 127);
    add_cmd(pidl_pkg::ACT_REPLACE, 32'ha5a5_a5a5, 3);
    add_cmd(pidl_pkg::ACT_DELETE, 32'h0, 0);
    add_cmd(pidl_pkg::ACT_DELETE, 32'h0, 4);
    add_cmd(pidl_pkg::ACT_DELETE, 32'h0, 127);
    add_cmd(ACT_SPARE_LO, 32'hffff_ffff, 127);
    add_cmd(ACT_SPARE_HI, 32'h0, 0);
    add_cmd(pidl_pkg::ACT_READ, 32'h0, 2);
    add_cmd(pidl_pkg::ACT_CLEAR, 32'h0, 0);
    add_cmd(pidl_pkg::ACT_READ, 32'h0, 0);
    add_cmd(pidl_pkg::ACT_INSERT, 32'h0, 127);

    while (gen_total < CMD_TARGET) begin
      if ($urandom_range(99) < 75) begin
        // clear, fill to a length, then edit around live positions
        add_cmd(pidl_pkg::ACT_CLEAR, rand_word(), pick_pos(0));
        target = ($urandom_range(19) == 0) ? $urandom_range(120, LIST_DEPTH)
                                           : $urandom_range(16);
        while (gen_len < target) add_cmd(pidl_pkg::ACT_APPEND, rand_word(), pick_pos(0));
        if (gen_len == LIST_DEPTH) begin
          add_cmd(pidl_pkg::ACT_APPEND, rand_word(), pick_pos(0));
          add_cmd(pidl_pkg::ACT_INSERT, rand_word(), pick_pos(gen_len));
        end
        ops = $urandom_range(8, 24);
        for (int j = 0; j < ops; j++) begin
          k = $urandom_range(99);
          if (k < 30) act = pidl_pkg::ACT_READ;
          else if (k < 45) act = pidl_pkg::ACT_INSERT;
          else if (k < 60) act = pidl_pkg::ACT_REPLACE;
          else if (k < 75) act = pidl_pkg::ACT_DELETE;
          else if (k < 92) act = pidl_pkg::ACT_APPEND;
          else if (k < 95) act = pidl_pkg::ACT_CLEAR;
          else act = ($urandom_range(1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
          add_cmd(act, rand_word(),
                  pick_pos((act == pidl_pkg::ACT_INSERT) ? gen_len + 1 : gen_len));
        end
      end else begin
        for (int j = 0; j < 6; j++) add_cmd(3'($urandom_range(7)), $urandom, $urandom_range(127));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_q.size() != 0 || in_tvalid || list_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_errors == 0 && list_results_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
